// ----- rtl/core/jsd_pkg.sv -----
// Shared types, codes and defaults for the job slot dispatcher.
package jsd_pkg;

    localparam int SLOTS_DEF       = 32;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_OUT         = 32;
    localparam int DISP_W          = $clog2(MAX_OUT + 1);
    localparam int CODE_W          = 32;
    localparam int ARG_W           = 32;
    localparam int SLOT_W          = 5;
    localparam int KIND_W          = 2;
    localparam int STAT_W          = 2;
    localparam int QDATA_W         = CODE_W + ARG_W;
    localparam int CMD_DEPTH       = 2;
    localparam int TDATA_W         = 72;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_SPAWN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_DISPATCH = 2'd0,
        STAT_QUEUED   = 2'd1,
        STAT_REJECT   = 2'd2,
        STAT_NONE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_SPAWN,
        OP_FINISH,
        OP_UPDATE,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [ARG_W-1:0]  arg;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REAP,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/core/job_slot_dispatcher_core.sv -----
// Job slot dispatcher: a spawn, finish or unknown word passes from input accept through the
// command buffer, then the back end, to the result; one word per cycle sustained while the
// result is not stalled and no update runs. An update takes the command, then a reap state,
// then a read and an emit state per dispatched job, bounded by the registered read port of
// the pending queue RAM; with nothing to dispatch its result is loaded in the read state.
// Synchronous active-low reset clears slot bitmaps, queue pointers and all valid flags;
// the queue RAM holds no reset value and needs no clearing pass.
module job_slot_dispatcher_core #(
    parameter int SLOTS       = jsd_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = jsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // job_code[31:0], job_arg[63:32], slot[68:64], zero pad
    input  logic [jsd_pkg::TDATA_W-1:0]   i_s_tdata,
    // kind[1:0]
    input  logic [jsd_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_slot[4:0], out_code[36:5], out_arg[68:37], zero pad
    output logic [jsd_pkg::TDATA_W-1:0]   o_m_tdata,
    // status[1:0]
    output logic [jsd_pkg::STAT_W-1:0]    o_m_tuser,
    output logic                          o_m_tlast
);

    logic          cmd_valid, cmd_ready;
    jsd_pkg::t_cmd cmd;

    jsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    jsd_back #(
        .SLOTS       (SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ----- rtl/core/jsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/jsd_front.sv -----
// Front end: accepts input words, classifies the kind and buffers commands.
module jsd_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    input  logic [jsd_pkg::TDATA_W-1:0]             i_s_tdata,
    input  logic [jsd_pkg::KIND_W-1:0]              i_s_tuser,
    output logic                                    o_cmd_valid,
    output jsd_pkg::t_cmd                           o_cmd,
    input  logic                                    i_cmd_ready
);

    jsd_pkg::t_cmd r_q [jsd_pkg::CMD_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;
    jsd_pkg::t_cmd cmd_in;

    always_comb begin
        case (i_s_tuser)
            jsd_pkg::KIND_SPAWN:  cmd_in.op = jsd_pkg::OP_SPAWN;
            jsd_pkg::KIND_FINISH: cmd_in.op = jsd_pkg::OP_FINISH;
            jsd_pkg::KIND_UPDATE: cmd_in.op = jsd_pkg::OP_UPDATE;
            default:              cmd_in.op = jsd_pkg::OP_NONE;
        endcase
        cmd_in.code = i_s_tdata[31:0];
        cmd_in.arg  = i_s_tdata[63:32];
        cmd_in.slot = i_s_tdata[68:64];
    end

    assign o_s_tready  = (r_cnt != 2'(jsd_pkg::CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- rtl/core/jsd_back.sv -----
// Back end: slot bitmaps, pending job queue, reap/dispatch sequencer, result register.
module jsd_back #(
    parameter int SLOTS       = jsd_pkg::SLOTS_DEF,
    parameter int QUEUE_DEPTH = jsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  jsd_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_ready,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [jsd_pkg::TDATA_W-1:0]   o_m_tdata,
    output logic [jsd_pkg::STAT_W-1:0]    o_m_tuser,
    output logic                          o_m_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    jsd_pkg::t_state r_state, n_state;

    logic [SLOTS-1:0]            r_active, n_active;
    logic [SLOTS-1:0]            r_fin, n_fin;
    logic [AW-1:0]               r_head, n_head;
    logic [AW-1:0]               r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count;
    logic [jsd_pkg::DISP_W-1:0]  r_n, n_n;

    logic                        r_out_valid, n_out_valid;
    jsd_pkg::t_status            r_out_stat, n_out_stat;
    logic [jsd_pkg::SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [jsd_pkg::CODE_W-1:0]  r_out_code, n_out_code;
    logic [jsd_pkg::ARG_W-1:0]   r_out_arg, n_out_arg;
    logic                        r_out_last, n_out_last;

    logic                        out_free;
    logic                        found;
    logic [SW-1:0]               free_idx;
    logic [6:0]                  free_idx7;
    logic [SLOTS-1:0]            free_hot;
    logic [SLOTS-1:0]            fin_hit;
    logic [SLOTS-1:0]            reap;
    logic                        q_full, q_empty;

    logic                        ram_we, ram_re;
    logic [jsd_pkg::QDATA_W-1:0] ram_rdata;

    assign out_free  = !r_out_valid || i_m_tready;
    assign q_full    = (r_count == CW'(QUEUE_DEPTH));
    assign q_empty   = (r_count == '0);
    assign reap      = r_active & r_fin;
    assign free_idx7 = 7'(free_idx);

    // Lowest inactive slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                found    = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_hot[i] = found && (free_idx == SW'(i));
            fin_hit[i]  = (7'(i_cmd.slot) == 7'(i));
        end
    end

    jsd_ram #(
        .WIDTH (jsd_pkg::QDATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({i_cmd.arg, i_cmd.code}),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jsd_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.op == jsd_pkg::OP_UPDATE) begin
                    n_state = jsd_pkg::ST_REAP;
                end
            end
            jsd_pkg::ST_REAP: n_state = jsd_pkg::ST_READ;
            jsd_pkg::ST_READ: begin
                if (q_empty || !found) begin
                    if (out_free) begin
                        n_state = jsd_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = jsd_pkg::ST_EMIT;
                end
            end
            jsd_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = n_out_last ? jsd_pkg::ST_IDLE : jsd_pkg::ST_READ;
                end
            end
            default: n_state = jsd_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_active    = r_active;
        n_fin       = r_fin;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_stat  = r_out_stat;
        n_out_slot  = r_out_slot;
        n_out_code  = r_out_code;
        n_out_arg   = r_out_arg;
        n_out_last  = r_out_last;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            jsd_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == jsd_pkg::OP_UPDATE) begin
                        o_cmd_ready = 1'b1;
                    end else if (out_free) begin
                        o_cmd_ready = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_stat  = jsd_pkg::STAT_NONE;
                        n_out_slot  = '0;
                        n_out_code  = '0;
                        n_out_arg   = '0;
                        n_out_last  = 1'b1;
                        case (i_cmd.op)
                            jsd_pkg::OP_SPAWN: begin
                                if (found) begin
                                    n_active   = r_active | free_hot;
                                    n_fin      = r_fin & ~free_hot;
                                    n_out_stat = jsd_pkg::STAT_DISPATCH;
                                    n_out_slot = free_idx7[4:0];
                                    n_out_code = i_cmd.code;
                                    n_out_arg  = i_cmd.arg;
                                end else if (!q_full) begin
                                    ram_we     = 1'b1;
                                    n_tail     = (r_tail == AW'(QUEUE_DEPTH - 1)) ?
                                                 '0 : r_tail + 1'b1;
                                    n_count    = r_count + 1'b1;
                                    n_out_stat = jsd_pkg::STAT_QUEUED;
                                end else begin
                                    n_out_stat = jsd_pkg::STAT_REJECT;
                                end
                            end
                            jsd_pkg::OP_FINISH: begin
                                // ignore out-of-range or idle slots
                                n_fin = r_fin | (fin_hit & r_active);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            jsd_pkg::ST_REAP: begin
                n_active = r_active & ~reap;
                n_fin    = r_fin & ~reap;
                n_n      = '0;
            end
            jsd_pkg::ST_READ: begin
                if (q_empty || !found) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_stat  = jsd_pkg::STAT_NONE;
                        n_out_slot  = '0;
                        n_out_code  = '0;
                        n_out_arg   = '0;
                        n_out_last  = 1'b1;
                    end
                end else begin
                    ram_re = 1'b1;
                end
            end
            jsd_pkg::ST_EMIT: begin
                n_out_last = (r_n == jsd_pkg::DISP_W'(jsd_pkg::MAX_OUT - 1)) ||
                             (r_count == CW'(1)) || (&(r_active | free_hot));
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_stat  = jsd_pkg::STAT_DISPATCH;
                    n_out_slot  = free_idx7[4:0];
                    n_out_code  = ram_rdata[jsd_pkg::CODE_W-1:0];
                    n_out_arg   = ram_rdata[jsd_pkg::QDATA_W-1:jsd_pkg::CODE_W];
                    n_active    = r_active | free_hot;
                    n_fin       = r_fin & ~free_hot;
                    n_head      = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count     = r_count - 1'b1;
                    n_n         = r_n + 1'b1;
                end else begin
                    n_out_last = r_out_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jsd_pkg::ST_IDLE;
            r_active    <= '0;
            r_fin       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_fin       <= n_fin;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_stat <= n_out_stat;
        r_out_slot <= n_out_slot;
        r_out_code <= n_out_code;
        r_out_arg  <= n_out_arg;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_stat;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'b000, r_out_arg, r_out_code, r_out_slot};

endmodule

// ----- rtl/core/jsd_checker.sv -----
// Port-level checks for the job slot dispatcher, bound to the top level.
module jsd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [jsd_pkg::TDATA_W-1:0] o_m_tdata,
    input logic [jsd_pkg::STAT_W-1:0]  o_m_tuser,
    input logic                        o_m_tlast
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    // only a dispatch carries slot, code and argument
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != jsd_pkg::STAT_DISPATCH) |-> (o_m_tdata == '0))
        else $error("non-dispatch result carries payload");

    // non-dispatch results are always the single result of their input
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != jsd_pkg::STAT_DISPATCH) |-> o_m_tlast)
        else $error("non-dispatch result without last");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind job_slot_dispatcher_core jsd_checker u_jsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
